// ===== design/mcra_pkg.sv =====
package mcra_pkg;

  // Fixed-point constants used by the update arithmetic.
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [15:0] HALF_Q16  = 16'h8000;
  localparam logic [11:0] HALF_Q12  = 12'h800;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIME_SMOOTHING    = 3'd0;
  localparam logic [2:0] CFG_MIN_UPDATE_WEIGHT = 3'd1;
  localparam logic [2:0] CFG_MIN_WINDOW_FRAMES = 3'd2;
  localparam logic [2:0] CFG_FLOOR_RATIO       = 3'd3;
  localparam logic [2:0] CFG_STARTUP_FRAMES    = 3'd4;
  localparam logic [2:0] CFG_NOISE_GAIN        = 3'd5;
  localparam logic [2:0] CFG_BINS_IN_USE       = 3'd6;
  localparam logic [2:0] CFG_CHANNELS_IN_USE   = 3'd7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  typedef struct packed {
    logic [15:0] time_smoothing;
    logic [15:0] min_update_weight;
    logic [15:0] min_window_frames;
    logic [15:0] floor_ratio;
    logic [15:0] startup_frames;
    logic [15:0] noise_gain;
    logic [9:0]  bins_in_use;
    logic [3:0]  channels_in_use;
  } cfg_t;

  // One pending noise update handed from the front to the back.
  typedef struct packed {
    logic [2:0]  channel;
    logic [8:0]  bin;
    logic [31:0] power;
    logic [31:0] smooth;
    logic [31:0] smooth_f;
    logic        frame_last;
  } job_t;

  typedef enum logic [1:0] {FR_CLEAR, FR_IDLE, FR_CALC, FR_PUSH2} front_state_t;

  typedef enum logic [2:0] {BK_CLEAR, BK_IDLE, BK_MIN, BK_COND, BK_MIX, BK_OUT}
    back_state_t;

endpackage

// ===== design/mcra_fifo.sv =====
module mcra_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mcra_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output mcra_pkg::job_t head,
  output logic           empty
);

  mcra_pkg::job_t entries [mcra_pkg::FIFO_DEPTH];
  logic [mcra_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [mcra_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [mcra_pkg::FIFO_PTR_W:0]   count;

  assign full  = (count == (mcra_pkg::FIFO_PTR_W+1)'(mcra_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/mcra_front.sv =====
module mcra_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BINS     = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  mcra_pkg::cfg_t cfg,
  input  logic           item_valid,
  output logic           item_ready,
  input  logic [31:0]    power,
  input  logic [2:0]     channel,
  input  logic [8:0]     bin,
  output logic           push,
  output mcra_pkg::job_t push_data,
  input  logic           full
);

  localparam int DEPTH  = MAX_CHANNELS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIMB   = (MAX_BINS < 512) ? MAX_BINS : 512;

  mcra_pkg::front_state_t state, state_next;

  logic [31:0] smooth_mem [DEPTH];
  logic [31:0] rd_s;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr_in;
  logic [ADDR_W-1:0] addr_q;
  logic [31:0] p_q;
  logic [2:0]  ch_q;
  logic [8:0]  b_q;
  logic        lastb_q;
  logic        lastc_q;
  logic [31:0] pend_p;
  logic [31:0] pend_s;
  logic [31:0] earlier;

  logic [9:0] nb_c;
  logic [3:0] nc_c;
  logic       accept;
  logic       in_range;

  logic signed [33:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] tot;
  logic [31:0] s_new;
  logic [33:0] sf1_sum;
  logic [33:0] sf2_sum;
  logic        calc_go;
  logic        mem_we;

  always_comb begin
    if (cfg.bins_in_use < 10'd2) begin
      nb_c = 10'd2;
    end else if (int'(cfg.bins_in_use) > LIMB) begin
      nb_c = 10'(LIMB);
    end else begin
      nb_c = cfg.bins_in_use;
    end
    if (cfg.channels_in_use < 4'd1) begin
      nc_c = 4'd1;
    end else if (int'(cfg.channels_in_use) > MAX_CHANNELS) begin
      nc_c = 4'(MAX_CHANNELS);
    end else begin
      nc_c = cfg.channels_in_use;
    end
  end

  assign item_ready = (state == mcra_pkg::FR_IDLE);
  assign accept     = item_valid && item_ready;
  assign in_range   = ({1'b0, channel} < nc_c) && ({1'b0, bin} < nb_c);
  assign addr_in    = ADDR_W'(int'(channel) * MAX_BINS + int'(bin));

  // New smoothed power: 65536*p + a*(S-p), rounded.
  assign diff  = $signed({2'b00, rd_s}) - $signed({2'b00, p_q});
  assign prod  = $signed({1'b0, cfg.time_smoothing}) * diff;
  assign tot   = $signed({3'b000, p_q, 16'h0000}) + prod
               + $signed({35'd0, mcra_pkg::HALF_Q16});
  assign s_new = tot[47:16];

  assign sf1_sum = {2'b00, earlier} + {1'b0, pend_s, 1'b0} + {2'b00, s_new} + 34'd2;
  assign sf2_sum = {2'b00, earlier} + {1'b0, pend_s, 1'b0} + 34'd2;

  assign calc_go = (state == mcra_pkg::FR_CALC) && ((b_q == 9'd0) || !full);
  assign mem_we  = calc_go || (state == mcra_pkg::FR_CLEAR);

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_data  = '0;
    unique case (state)
      mcra_pkg::FR_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = mcra_pkg::FR_IDLE;
        end
      end
      mcra_pkg::FR_IDLE: begin
        if (accept && in_range) begin
          state_next = mcra_pkg::FR_CALC;
        end
      end
      mcra_pkg::FR_CALC: begin
        if (calc_go) begin
          if (b_q != 9'd0) begin
            push                = 1'b1;
            push_data.channel   = ch_q;
            push_data.bin       = b_q - 9'd1;
            push_data.power     = pend_p;
            push_data.smooth    = pend_s;
            push_data.smooth_f  = sf1_sum[33:2];
            push_data.frame_last = 1'b0;
          end
          state_next = lastb_q ? mcra_pkg::FR_PUSH2 : mcra_pkg::FR_IDLE;
        end
      end
      mcra_pkg::FR_PUSH2: begin
        if (!full) begin
          push                 = 1'b1;
          push_data.channel    = ch_q;
          push_data.bin        = b_q;
          push_data.power      = pend_p;
          push_data.smooth     = pend_s;
          push_data.smooth_f   = sf2_sum[33:2];
          push_data.frame_last = lastc_q;
          state_next           = mcra_pkg::FR_IDLE;
        end
      end
      default: state_next = mcra_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mcra_pkg::FR_CLEAR;
      clr_addr <= '0;
      pend_p   <= '0;
      pend_s   <= '0;
      earlier  <= '0;
    end else begin
      state <= state_next;
      if (state == mcra_pkg::FR_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (calc_go) begin
        earlier <= (b_q == 9'd0) ? 32'd0 : pend_s;
        pend_s  <= s_new;
        pend_p  <= p_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_q     <= power;
      ch_q    <= channel;
      b_q     <= bin;
      addr_q  <= addr_in;
      lastb_q <= ({1'b0, bin} == nb_c - 10'd1);
      lastc_q <= ({1'b0, channel} == nc_c - 4'd1);
      rd_s    <= smooth_mem[addr_in];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (state == mcra_pkg::FR_CLEAR) begin
        smooth_mem[clr_addr] <= '0;
      end else begin
        smooth_mem[addr_q] <= s_new;
      end
    end
  end

endmodule

// ===== design/mcra_div.sv =====
module mcra_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic [16:0] quotient
);

  // Restoring division of 65536 by the divisor, one quotient bit a cycle.
  logic [4:0]  cnt;
  logic [16:0] rem;
  logic [16:0] dvd;
  logic [16:0] dsr;
  logic [17:0] trial;

  assign trial = {rem, dvd[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd17;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= mcra_pkg::ONE_Q16;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[15:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem      <= 17'(trial - {1'b0, dsr});
        quotient <= {quotient[15:0], 1'b1};
      end else begin
        rem      <= trial[16:0];
        quotient <= {quotient[15:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/mcra_back.sv =====
module mcra_back #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BINS     = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  mcra_pkg::cfg_t cfg,
  input  mcra_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [31:0]    noise_power,
  output logic [2:0]     out_channel,
  output logic [8:0]     out_bin,
  output logic           frame_end
);

  localparam int DEPTH  = MAX_CHANNELS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  mcra_pkg::back_state_t state, state_next;

  logic [31:0] run_mem   [DEPTH];
  logic [31:0] win_mem   [DEPTH];
  logic [31:0] noise_mem [DEPTH];
  logic [31:0] rd_run;
  logic [31:0] rd_win;
  logic [31:0] rd_noise;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] head_addr;
  logic [ADDR_W-1:0] addr_q;
  mcra_pkg::job_t    job;

  logic [15:0] frame_count;
  logic [15:0] window_position;
  logic        div_kick;
  logic        div_busy;
  logic [16:0] base_w;

  logic [31:0] smin;
  logic [31:0] stmp;
  logic [31:0] smin_q;
  logic [31:0] noise_q;
  logic [47:0] gp_sum;
  logic [35:0] gp_q;
  logic [47:0] floor_prod;
  logic        cond;
  logic [16:0] w_q;
  logic [48:0] mix1_q;
  logic [52:0] mix2;
  logic [53:0] acc_sum;
  logic [37:0] acc;
  logic [31:0] acc_sat;
  logic        out_go;
  logic [15:0] win_len;
  logic [16:0] pos;

  mcra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_kick),
    .divisor  ({1'b0, frame_count} + 17'd1),
    .busy     (div_busy),
    .quotient (base_w)
  );

  assign head_addr = ADDR_W'(int'(head.channel) * MAX_BINS + int'(head.bin));

  always_comb begin
    if (window_position == 16'd0) begin
      smin = (rd_win < job.smooth_f) ? rd_win : job.smooth_f;
      stmp = job.smooth_f;
    end else begin
      smin = (rd_run < job.smooth_f) ? rd_run : job.smooth_f;
      stmp = (rd_win < job.smooth_f) ? rd_win : job.smooth_f;
    end
  end

  assign gp_sum     = cfg.noise_gain * job.power + {36'd0, mcra_pkg::HALF_Q12};
  assign floor_prod = smin_q * cfg.floor_ratio;
  assign cond = ({4'd0, job.smooth_f, 12'd0} < floor_prod)
             || (frame_count < cfg.startup_frames)
             || (noise_q > job.smooth);

  assign mix2    = w_q * gp_q;
  assign acc_sum = {5'd0, mix1_q} + {1'b0, mix2} + {38'd0, mcra_pkg::HALF_Q16};
  assign acc     = acc_sum[53:16];
  assign acc_sat = (acc[37:32] != 6'd0) ? 32'hFFFF_FFFF : acc[31:0];

  assign out_go  = (state == mcra_pkg::BK_OUT) && (!result_valid || result_ready);
  assign win_len = (cfg.min_window_frames == 16'd0) ? 16'd1 : cfg.min_window_frames;
  assign pos     = {1'b0, window_position} + 17'd1;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      mcra_pkg::BK_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = mcra_pkg::BK_IDLE;
        end
      end
      mcra_pkg::BK_IDLE: begin
        if (!empty && !div_busy && !div_kick) begin
          pop        = 1'b1;
          state_next = mcra_pkg::BK_MIN;
        end
      end
      mcra_pkg::BK_MIN:  state_next = mcra_pkg::BK_COND;
      mcra_pkg::BK_COND: state_next = mcra_pkg::BK_MIX;
      mcra_pkg::BK_MIX:  state_next = mcra_pkg::BK_OUT;
      mcra_pkg::BK_OUT: begin
        if (out_go) begin
          state_next = mcra_pkg::BK_IDLE;
        end
      end
      default: state_next = mcra_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mcra_pkg::BK_CLEAR;
      clr_addr        <= '0;
      frame_count     <= '0;
      window_position <= '0;
      div_kick        <= 1'b1;
      result_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      div_kick <= 1'b0;
      if (state == mcra_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (out_go && job.frame_last) begin
        if (frame_count != 16'hFFFF) begin
          frame_count <= frame_count + 16'd1;
        end
        window_position <= (pos >= {1'b0, win_len}) ? 16'd0 : pos[15:0];
        div_kick        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job      <= head;
      addr_q   <= head_addr;
      rd_run   <= run_mem[head_addr];
      rd_win   <= win_mem[head_addr];
      rd_noise <= noise_mem[head_addr];
    end
    if (state == mcra_pkg::BK_MIN) begin
      smin_q  <= smin;
      noise_q <= rd_noise;
      gp_q    <= gp_sum[47:12];
    end
    if (state == mcra_pkg::BK_COND) begin
      if (cond) begin
        w_q <= (base_w < {1'b0, cfg.min_update_weight}) ?
               {1'b0, cfg.min_update_weight} : base_w;
      end else begin
        w_q <= '0;
      end
    end
    if (state == mcra_pkg::BK_MIX) begin
      mix1_q <= (mcra_pkg::ONE_Q16 - w_q) * noise_q;
    end
    if (out_go) begin
      noise_power <= acc_sat;
      out_channel <= job.channel;
      out_bin     <= job.bin;
      frame_end   <= job.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcra_pkg::BK_CLEAR) begin
      run_mem[clr_addr] <= '0;
      win_mem[clr_addr] <= '0;
    end else if (state == mcra_pkg::BK_MIN) begin
      run_mem[addr_q] <= smin;
      win_mem[addr_q] <= stmp;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcra_pkg::BK_CLEAR) begin
      noise_mem[clr_addr] <= '0;
    end else if (out_go) begin
      noise_mem[addr_q] <= acc_sat;
    end
  end

endmodule

// ===== design/mcra_noise_estimator.sv =====
// Minima-controlled recursive averaging noise estimator.
//
// Power-spectrum bins enter as words on the item channel (power, channel, bin),
// in bin order within each channel. Noise estimates leave as words on the result
// channel. The result for a bin is produced when the next bin of that channel
// arrives; the last bin in use of a channel produces two words, and frame_end
// marks the final word of the last channel in use.
//
// The front takes a new word only once it is done with the last: bin zero and
// ordinary bins pass through its calculate state, and the last bin of a channel
// also through its second push state; it is bounded by the read-modify-write of
// the smoothed-power memory. For each result word the back steps through its
// idle, minimum, condition, mix and output states for its reads, four multiplies
// and the write of the noise memory, which sets the sustained rate. A four-entry
// queue between front and back lets the front keep accepting while the back
// waits on a stalled receiver; the finished word is held in the output register
// until taken.
//
// After reset both parts sweep all MAX_CHANNELS*MAX_BINS memory entries to
// zero, one entry a cycle; item_ready stays low meanwhile. After each frame the
// back recomputes the update weight before its next word. The user must write
// configuration via cfg_we, cfg_index, cfg_data only while idle; not enforced.
module mcra_noise_estimator #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BINS     = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [31:0] power,
  input  logic [2:0]  channel,
  input  logic [8:0]  bin,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] noise_power,
  output logic [2:0]  out_channel,
  output logic [8:0]  out_bin,
  output logic        frame_end
);

  mcra_pkg::cfg_t cfg;
  mcra_pkg::job_t push_data;
  mcra_pkg::job_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  // Configuration registers; each keeps only the bits of its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_smoothing    <= 16'd45875;
      cfg.min_update_weight <= 16'd3277;
      cfg.min_window_frames <= 16'd150;
      cfg.floor_ratio       <= 16'd205;
      cfg.startup_frames    <= 16'd100;
      cfg.noise_gain        <= 16'd4096;
      cfg.bins_in_use       <= 10'd512;
      cfg.channels_in_use   <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcra_pkg::CFG_TIME_SMOOTHING:    cfg.time_smoothing    <= cfg_data;
        mcra_pkg::CFG_MIN_UPDATE_WEIGHT: cfg.min_update_weight <= cfg_data;
        mcra_pkg::CFG_MIN_WINDOW_FRAMES: cfg.min_window_frames <= cfg_data;
        mcra_pkg::CFG_FLOOR_RATIO:       cfg.floor_ratio       <= cfg_data;
        mcra_pkg::CFG_STARTUP_FRAMES:    cfg.startup_frames    <= cfg_data;
        mcra_pkg::CFG_NOISE_GAIN:        cfg.noise_gain        <= cfg_data;
        mcra_pkg::CFG_BINS_IN_USE:       cfg.bins_in_use       <= cfg_data[9:0];
        mcra_pkg::CFG_CHANNELS_IN_USE:   cfg.channels_in_use   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The front smooths power over time and frequency and queues updates.
  mcra_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BINS     (MAX_BINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .power      (power),
    .channel    (channel),
    .bin        (bin),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  mcra_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // The back tracks minima, updates the noise and drives the result word.
  mcra_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BINS     (MAX_BINS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .noise_power  (noise_power),
    .out_channel  (out_channel),
    .out_bin      (out_bin),
    .frame_end    (frame_end)
  );

endmodule

// ===== design/mcra_checker.sv =====
module mcra_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] noise_power,
  input logic [8:0]  out_bin,
  input logic        frame_end
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(noise_power))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_ready)
    else $error("activity right after reset");

  a_frame_end_bin: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> out_bin != 9'd0)
    else $error("frame end on bin zero");

endmodule

bind mcra_noise_estimator mcra_checker u_checker (.*);

// ===== sim/mcra_noise_checker.sv =====
module mcra_noise_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [31:0] power,
  input  logic [2:0]  channel,
  input  logic [8:0]  bin,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [31:0] noise_power,
  input  logic [2:0]  out_channel,
  input  logic [8:0]  out_bin,
  input  logic        frame_end,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 8;
  localparam int NBIN = 512;
  localparam int NSTORE = NCH * NBIN;

  typedef struct packed {
    logic [31:0] noise;
    logic [2:0]  ch;
    logic [8:0]  b;
    logic        last;
  } noise_word_t;

  logic [15:0] cfg_regs [8];
  logic [31:0] sp_mem [NSTORE];
  logic [31:0] smin_mem [NSTORE];
  logic [31:0] stmp_mem [NSTORE];
  logic [31:0] noise_mem [NSTORE];
  logic [31:0] held_power, held_smooth, left_smooth;
  logic [15:0] frames_seen, win_pos;
  noise_word_t noise_queue [$];

  assign pending_count = noise_queue.size();

  function automatic logic [31:0] min32(logic [31:0] x, logic [31:0] y);
    return x < y ? x : y;
  endfunction

  // Updates one bin's minima and noise and queues the predicted word.
  task automatic update_noise(input int c, input int b, input logic [31:0] p,
                              input logic [31:0] s, input logic [31:0] sf,
                              input logic last);
    int idx;
    logic [31:0] smin, stmp;
    logic [63:0] w, base, gp, acc;
    noise_word_t nw;
    idx = c * NBIN + b;
    if (win_pos == 16'd0) begin
      smin = min32(stmp_mem[idx], sf);
      stmp = sf;
    end else begin
      smin = min32(smin_mem[idx], sf);
      stmp = min32(stmp_mem[idx], sf);
    end
    smin_mem[idx] = smin;
    stmp_mem[idx] = stmp;
    w = 64'd0;
    if (64'(sf) * 64'd4096 < 64'(smin) * 64'(cfg_regs[mcra_pkg::CFG_FLOOR_RATIO]) ||
        frames_seen < cfg_regs[mcra_pkg::CFG_STARTUP_FRAMES] || noise_mem[idx] > s) begin
      base = 64'd65536 / (64'(frames_seen) + 64'd1);
      w = base < 64'(cfg_regs[mcra_pkg::CFG_MIN_UPDATE_WEIGHT]) ?
          64'(cfg_regs[mcra_pkg::CFG_MIN_UPDATE_WEIGHT]) : base;
    end
    gp = (64'(cfg_regs[mcra_pkg::CFG_NOISE_GAIN]) * 64'(p) + 64'd2048) >> 12;
    acc = ((64'd65536 - w) * 64'(noise_mem[idx]) + w * gp + 64'd32768) >> 16;
    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    noise_mem[idx] = acc[31:0];
    nw.noise = acc[31:0];
    nw.ch = c[2:0];
    nw.b = b[8:0];
    nw.last = last;
    noise_queue.push_back(nw);
  endtask

  task automatic predict_bin(input logic [31:0] p, input int c, input int b);
    int nb, nc, idx, wl;
    logic [15:0] a;
    logic [31:0] s;
    logic [63:0] sf;
    nb = int'(cfg_regs[mcra_pkg::CFG_BINS_IN_USE][9:0]);
    nc = int'(cfg_regs[mcra_pkg::CFG_CHANNELS_IN_USE][3:0]);
    if (nb < 2) nb = 2;
    if (nb > NBIN) nb = NBIN;
    if (nc < 1) nc = 1;
    if (nc > NCH) nc = NCH;
    if (c >= nc || b >= nb) return;
    a = cfg_regs[mcra_pkg::CFG_TIME_SMOOTHING];
    idx = c * NBIN + b;
    s = 32'((64'(a) * 64'(sp_mem[idx]) + (64'd65536 - 64'(a)) * 64'(p) + 64'd32768) >> 16);
    sp_mem[idx] = s;
    if (b == 0) begin
      left_smooth = 32'd0;
    end else begin
      sf = (64'(left_smooth) + 64'd2 * 64'(held_smooth) + 64'(s) + 64'd2) >> 2;
      update_noise(c, b - 1, held_power, held_smooth, sf[31:0], 1'b0);
      left_smooth = held_smooth;
    end
    held_smooth = s;
    held_power = p;
    if (b == nb - 1) begin
      sf = (64'(left_smooth) + 64'd2 * 64'(s) + 64'd2) >> 2;
      update_noise(c, b, p, s, sf[31:0], c == nc - 1);
      if (c == nc - 1) begin
        wl = cfg_regs[mcra_pkg::CFG_MIN_WINDOW_FRAMES] == 16'd0 ? 1 :
             int'(cfg_regs[mcra_pkg::CFG_MIN_WINDOW_FRAMES]);
        if (frames_seen != 16'hFFFF) frames_seen++;
        win_pos = (int'(win_pos) + 1 >= wl) ? 16'd0 : win_pos + 16'd1;
      end
    end
  endtask

  always @(posedge clk) begin
    noise_word_t got, want;
    if (rst) begin
      cfg_regs[mcra_pkg::CFG_TIME_SMOOTHING]    <= 16'd45875;
      cfg_regs[mcra_pkg::CFG_MIN_UPDATE_WEIGHT] <= 16'd3277;
      cfg_regs[mcra_pkg::CFG_MIN_WINDOW_FRAMES] <= 16'd150;
      cfg_regs[mcra_pkg::CFG_FLOOR_RATIO]       <= 16'd205;
      cfg_regs[mcra_pkg::CFG_STARTUP_FRAMES]    <= 16'd100;
      cfg_regs[mcra_pkg::CFG_NOISE_GAIN]        <= 16'd4096;
      cfg_regs[mcra_pkg::CFG_BINS_IN_USE]       <= 16'd512;
      cfg_regs[mcra_pkg::CFG_CHANNELS_IN_USE]   <= 16'd8;
      for (int i = 0; i < NSTORE; i++) begin
        sp_mem[i] = '0; smin_mem[i] = '0; stmp_mem[i] = '0; noise_mem[i] = '0;
      end
      held_power = '0; held_smooth = '0; left_smooth = '0;
      frames_seen = '0; win_pos = '0;
      noise_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcra_pkg::CFG_BINS_IN_USE:     cfg_regs[cfg_index] <= {6'd0, cfg_data[9:0]};
          mcra_pkg::CFG_CHANNELS_IN_USE: cfg_regs[cfg_index] <= {12'd0, cfg_data[3:0]};
          default:                       cfg_regs[cfg_index] <= cfg_data;
        endcase
      end
      if (item_valid && item_ready) predict_bin(power, int'(channel), int'(bin));
      if (result_valid && result_ready) begin
        got = '{noise_power, out_channel, out_bin, frame_end};
        if (noise_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected word: noise %0d ch %0d bin %0d end %0d",
                     got.noise, got.ch, got.b, got.last);
        end else begin
          want = noise_queue.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected noise %0d ch %0d bin %0d end %0d, got %0d %0d %0d %0d",
                       want.noise, want.ch, want.b, want.last,
                       got.noise, got.ch, got.b, got.last);
          end
        end
      end
    end
  end
endmodule

// ===== sim/mcra_noise_estimator_tb.sv =====
module mcra_noise_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 0;
  logic        item_ready;
  logic [31:0] power = '0;
  logic [2:0]  channel = '0;
  logic [8:0]  bin = '0;
  logic        result_valid;
  logic        result_ready = 0;
  logic [31:0] noise_power;
  logic [2:0]  out_channel;
  logic [8:0]  out_bin;
  logic        frame_end;
  int          fail_count, pending_count;

  // Idle and stall percentages of the current phase, and the long hold-off.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_left = 0;
  logic hold_done = 0;

  // Configuration in force as the stimulus sees it.
  int nbins = 512, nchans = 8;

  always #10 clk = ~clk;

  mcra_noise_estimator DUT (.*);

  mcra_noise_checker checker_i (.*);

  // The receiver stalls at random; a requested hold-off, counted down from
  // hold_len, keeps ready low so the internal queue fills and the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 0;
    end else if (hold_len > 0 && !hold_done) begin
      result_ready <= 0;
      hold_left <= hold_len - 1;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      result_ready <= 0;
      hold_left <= hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == mcra_pkg::CFG_BINS_IN_USE) begin
      nbins = val < 2 ? 2 : (val > 512 ? 512 : val);
    end
    if (idx == mcra_pkg::CFG_CHANNELS_IN_USE) begin
      nchans = val < 1 ? 1 : (val > 8 ? 8 : val);
    end
  endtask

  // Offers one word, with an optional random gap first, and waits until item_ready
  // is seen high. Valid stays high across back-to-back words.
  task automatic send_bin(input logic [31:0] p, input int c, input int b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    power <= p;
    channel <= c[2:0];
    bin <= b[8:0];
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_power();
    case ($urandom_range(4))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  // Waits for every expected word, then lets the back finish its weight pass.
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One whole frame of well-formed bins over the channels in use.
  task automatic send_frame();
    for (int c = 0; c < nchans; c++)
      for (int b = 0; b < nbins; b++)
        send_bin(rand_power(), c, b);
  endtask

  // Random words: mostly well-formed frames, some stray and out-of-range bins.
  task automatic random_phase(input int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(9) < 8) begin
        send_frame();
        sent += nbins * nchans;
      end else begin
        send_bin($urandom, $urandom_range(7), $urandom_range(511));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: small frame, extreme powers, out-of-range and
    // out-of-order bins, and the register extremes.
    write_reg(mcra_pkg::CFG_BINS_IN_USE, 3);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 2);
    send_bin(32'hFFFF_FFFF, 0, 0);
    send_bin(32'd0, 0, 1);
    send_bin(32'hFFFF_FFFF, 0, 2);
    send_bin(32'd5, 1, 0);
    send_bin(32'hFFFF_FFFF, 1, 1);
    send_bin(32'd7, 1, 2);
    send_bin(32'd9, 2, 0);
    send_bin(32'd9, 0, 3);
    send_bin(32'h5555_AAAA, 1, 2);
    send_bin(32'hAAAA_5555, 0, 0);
    send_bin(32'h1234_5678, 0, 2);
    send_bin(32'h1, 1, 1);
    drain();
    write_reg(mcra_pkg::CFG_TIME_SMOOTHING, 0);
    write_reg(mcra_pkg::CFG_MIN_UPDATE_WEIGHT, 65535);
    write_reg(mcra_pkg::CFG_MIN_WINDOW_FRAMES, 0);
    write_reg(mcra_pkg::CFG_FLOOR_RATIO, 65535);
    write_reg(mcra_pkg::CFG_STARTUP_FRAMES, 0);
    write_reg(mcra_pkg::CFG_NOISE_GAIN, 65535);
    write_reg(mcra_pkg::CFG_BINS_IN_USE, 0);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 0);
    send_bin(32'hFFFF_FFFF, 0, 0);
    send_bin(32'hFFFF_FFFF, 0, 1);
    send_bin(32'hFFFF_FFFF, 0, 1);
    send_bin(32'd3, 7, 511);
    drain();

    // No idling, with a long receiver hold-off while words keep coming.
    write_reg(mcra_pkg::CFG_TIME_SMOOTHING, 65535);
    write_reg(mcra_pkg::CFG_MIN_UPDATE_WEIGHT, 0);
    write_reg(mcra_pkg::CFG_MIN_WINDOW_FRAMES, 2);
    write_reg(mcra_pkg::CFG_FLOOR_RATIO, 0);
    write_reg(mcra_pkg::CFG_STARTUP_FRAMES, 65535);
    write_reg(mcra_pkg::CFG_NOISE_GAIN, 0);
    write_reg(mcra_pkg::CFG_BINS_IN_USE, 8);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 8);
    hold_len <= 300;
    random_phase(100);
    drain();

    write_reg(mcra_pkg::CFG_TIME_SMOOTHING, 45875);
    write_reg(mcra_pkg::CFG_MIN_UPDATE_WEIGHT, 3277);
    write_reg(mcra_pkg::CFG_MIN_WINDOW_FRAMES, 3);
    write_reg(mcra_pkg::CFG_FLOOR_RATIO, 205);
    write_reg(mcra_pkg::CFG_STARTUP_FRAMES, 4);
    write_reg(mcra_pkg::CFG_NOISE_GAIN, 4096);
    write_reg(mcra_pkg::CFG_BINS_IN_USE, 5);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 3);
    send_idle_pct = 69;
    random_phase(100);
    drain();

    write_reg(mcra_pkg::CFG_BINS_IN_USE, 2);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 1);
    write_reg(mcra_pkg::CFG_FLOOR_RATIO, 20000);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    random_phase(100);
    drain();

    write_reg(mcra_pkg::CFG_BINS_IN_USE, 16);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 2);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_phase(80);
    drain();

    // The top two bins at the largest bin count on a single channel.
    write_reg(mcra_pkg::CFG_BINS_IN_USE, 512);
    write_reg(mcra_pkg::CFG_CHANNELS_IN_USE, 1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_bin(rand_power(), 0, 510);
    send_bin(rand_power(), 0, 511);
    drain();

    if (fail_count == 0) begin
      $display("mcra_noise_estimator regression: pass");
    end else begin
      $display("mcra_noise_estimator regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("mcra_noise_estimator regression: fail");
    $finish;
  end
endmodule
